[hdl/siphash_2_4_stream_core_defines.svh]
// assertion macros used by siph_core of the siphash stream core
// no dependencies; included by siph_core, the file that carries assertions
`ifndef SIPHASH_2_4_STREAM_CORE_DEFINES_SVH
`define SIPHASH_2_4_STREAM_CORE_DEFINES_SVH

`ifndef SYNTH
`define SIPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SIPH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SIPH_ASSERT(lbl, prop, msg)
`define SIPH_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hdl/siph_pkg.sv]
// types and constants for the siphash-2-4 stream core
// no dependencies
package siph_pkg;

  localparam logic [63:0] SipC0 = 64'h736F_6D65_7073_6575;
  localparam logic [63:0] SipC1 = 64'h646F_7261_6E64_6F6D;
  localparam logic [63:0] SipC2 = 64'h6C79_6765_6E65_7261;
  localparam logic [63:0] SipC3 = 64'h7465_6462_7974_6573;
  localparam logic [63:0] FinXor = 64'h0000_0000_0000_00FF;
  localparam int unsigned LenShift = 56;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } siph_state_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LEN,
    PH_FIN1,
    PH_FIN2
  } siph_phase_e;

  typedef enum logic {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } siph_cfg_e;

endpackage

[hdl/siph_dround.sv]
// two sip rounds with message and finalization xors around them
// depends on siph_pkg
module siph_dround import siph_pkg::*; (
  input  siph_state_t state_i,
  input  logic [63:0] msg_i,
  input  logic        fin_i,
  output siph_state_t state_o
);

  function automatic siph_state_t sip_round(siph_state_t s);
    siph_state_t r;
    r = s;
    r.v0 = r.v0 + r.v1;
    r.v1 = {r.v1[50:0], r.v1[63:51]};
    r.v1 = r.v1 ^ r.v0;
    r.v0 = {r.v0[31:0], r.v0[63:32]};
    r.v2 = r.v2 + r.v3;
    r.v3 = {r.v3[47:0], r.v3[63:48]};
    r.v3 = r.v3 ^ r.v2;
    r.v0 = r.v0 + r.v3;
    r.v3 = {r.v3[42:0], r.v3[63:43]};
    r.v3 = r.v3 ^ r.v0;
    r.v2 = r.v2 + r.v1;
    r.v1 = {r.v1[46:0], r.v1[63:47]};
    r.v1 = r.v1 ^ r.v2;
    r.v2 = {r.v2[31:0], r.v2[63:32]};
    return r;
  endfunction

  siph_state_t pre;
  siph_state_t post;

  always_comb begin
    pre = state_i;
    pre.v3 = state_i.v3 ^ msg_i;
    pre.v2 = state_i.v2 ^ (fin_i ? FinXor : 64'd0);
    post = sip_round(sip_round(pre));
    state_o = post;
    state_o.v0 = post.v0 ^ msg_i;
  end

endmodule

[hdl/siph_core.sv]
// input word register, mixing state and last-word sequencer
// depends on siph_pkg, siph_dround and the assertion macro header
`include "siphash_2_4_stream_core_defines.svh"

module siph_core import siph_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] key_low_i,
  input  logic [63:0] key_high_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  input  logic        out_ready_i,
  output logic        res_valid_o,
  output logic [63:0] res_hash_o
);

  logic        hv_q;
  logic [63:0] hw_q;
  logic [3:0]  hc_q;
  logic        hl_q;

  siph_state_t state_q, state_d, src, init, rnd;
  siph_phase_e phase_q, phase_d;
  logic [7:0]  len_q, len_d, len_base, len_tail;
  logic        open_q, open_d;
  logic [63:0] msg, masked;
  logic        fin, full, step_en, item_done, accept;
  logic [2:0]  cnt3;

  assign full = hc_q[3];
  assign cnt3 = hc_q[2:0];

  assign init.v0 = key_low_i ^ SipC0;
  assign init.v1 = key_high_i ^ SipC1;
  assign init.v2 = key_low_i ^ SipC2;
  assign init.v3 = key_high_i ^ SipC3;

  assign len_base = open_q ? len_q : 8'd0;
  assign len_tail = len_base + {5'd0, cnt3};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (3'(i) < cnt3) ? hw_q[8*i +: 8] : 8'd0;
    end
  end

  always_comb begin
    src     = state_q;
    msg     = 64'd0;
    fin     = 1'b0;
    len_d   = len_q;
    open_d  = open_q;
    phase_d = phase_q;
    unique case (phase_q)
      PH_FIRST: begin
        src    = open_q ? state_q : init;
        open_d = 1'b1;
        if (!hl_q || full) begin
          msg   = hw_q;
          len_d = len_base + 8'd8;
        end else begin
          msg   = masked | ({56'd0, len_tail} << LenShift);
          len_d = len_tail;
        end
        if (hl_q) begin
          phase_d = full ? PH_LEN : PH_FIN1;
        end
      end
      PH_LEN: begin
        msg     = {56'd0, len_q} << LenShift;
        phase_d = PH_FIN1;
      end
      PH_FIN1: begin
        fin     = 1'b1;
        phase_d = PH_FIN2;
      end
      PH_FIN2: begin
        open_d  = 1'b0;
        phase_d = PH_FIRST;
      end
      default: begin
        phase_d = PH_FIRST;
      end
    endcase
  end

  siph_dround u_dround (
    .state_i (src),
    .msg_i   (msg),
    .fin_i   (fin),
    .state_o (rnd)
  );

  assign state_d     = rnd;
  assign step_en     = hv_q && ((phase_q != PH_FIN2) || out_ready_i);
  assign item_done   = hv_q && (((phase_q == PH_FIRST) && !hl_q) ||
                                ((phase_q == PH_FIN2) && out_ready_i));
  assign in_stall_o  = hv_q && !item_done;
  assign accept      = in_valid_i && !in_stall_o;
  assign res_valid_o = hv_q && (phase_q == PH_FIN2) && out_ready_i;
  assign res_hash_o  = rnd.v0 ^ rnd.v1 ^ rnd.v2 ^ rnd.v3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q    <= 1'b0;
      phase_q <= PH_FIRST;
      len_q   <= 8'd0;
      open_q  <= 1'b0;
    end else begin
      if (accept) begin
        hv_q <= 1'b1;
      end else if (item_done) begin
        hv_q <= 1'b0;
      end
      if (step_en) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        open_q  <= open_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hw_q <= message_word_i;
      hc_q <= byte_count_i;
      hl_q <= last_word_i;
    end
    if (step_en) begin
      state_q <= state_d;
    end
  end

  `SIPH_ASSERT(a_seq_holds_word, (phase_q != PH_FIRST) |-> hv_q, "sequencer runs without a word")
  `SIPH_ASSERT(a_res_in_fin2, res_valid_o |-> (phase_q == PH_FIN2), "hash outside final step")
  `SIPH_ASSERT(a_res_closes, res_valid_o |=> (!open_q && (phase_q == PH_FIRST)), "message not closed")
  `SIPH_ASSERT(a_fin_order, (phase_q == PH_FIN1) |=> (phase_q == PH_FIN2), "finalization skipped")
  `SIPH_ASSERT_RST(a_reset_idle, !rst_ni |-> (!hv_q && !open_q), "reset leaves word pending")

endmodule

[hdl/siphash_2_4_stream_core.sv]
// top level of the siphash-2-4 stream core: key registers, core and hash register
// depends on siph_pkg and siph_core
//
// Keyed SipHash-2-4 over messages given as little-endian 64-bit words. Write the key
// (index 0 key bytes 0-7, index 1 bytes 8-15) while idle; it is sampled at the first
// word of each message. Non-last words stream at one per clock while no last word is
// in progress. The last word holds the input for one pass of the shared two-round sip
// unit per block: tail block, length block when needed (byte_count 8 and above, counts
// over 8 act as 8), then two finalization passes. The final pass also waits while the
// previous hash is still held in the output register and the receiver stalls. The hash
// is registered in that register at the end of the final pass; words of the next
// message are taken while it waits.
module siphash_2_4_stream_core import siph_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  logic [63:0] key_low_q, key_high_q;
  logic        out_valid_q;
  logic [63:0] hash_q;
  logic        out_ready, res_valid;
  logic [63:0] res_hash;

  assign out_ready = !out_valid_q || !out_stall_i;

  siph_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_low_i      (key_low_q),
    .key_high_i     (key_high_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_word_i (message_word_i),
    .byte_count_i   (byte_count_i),
    .last_word_i    (last_word_i),
    .out_ready_i    (out_ready),
    .res_valid_o    (res_valid),
    .res_hash_o     (res_hash)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q   <= 64'd0;
      key_high_q  <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (siph_cfg_e'(cfg_index_i))
          CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
          CFG_KEY_HIGH: key_high_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      hash_q <= res_hash;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

[bench/tb_siphash_2_4_stream_core.sv]
`timescale 1ns / 100ps
// self-checking bench for siphash_2_4_stream_core: directed table, then random messages
// uses siph_pkg and the core; expected hashes come from an in-bench siphash-2-4 model or from the table row
module tb_siphash_2_4_stream_core;
  import siph_pkg::*;

  localparam logic [63:0] KeyStdLo = 64'h0706_0504_0302_0100;
  localparam logic [63:0] KeyStdHi = 64'h0F0E_0D0C_0B0A_0908;
  localparam logic [63:0] AllOnes  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          NumDir   = 19;
  localparam int          NumPhase = 6;
  localparam int          HoldLen  = 400;

  typedef struct {
    bit          set_key;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [63:0] word;
    logic [3:0]  count;
    bit          last;
    bit          has_hash;
    logic [63:0] hash;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] message_word_i;
  logic [3:0]  byte_count_i;
  logic        last_word_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] hash_value_o;

  siph_state_t mix;
  logic [7:0]  len_byte;
  logic        msg_open;
  logic [63:0] key_lo_q;
  logic [63:0] key_hi_q;

  logic [63:0] pending_hashes [$];
  logic [63:0] hash_want;
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_mark = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  dir_row_t    dir_rows [NumDir];

  siphash_2_4_stream_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_word_i (message_word_i),
    .byte_count_i   (byte_count_i),
    .last_word_i    (last_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic siph_state_t sip_round(input siph_state_t s);
    s.v0 = s.v0 + s.v1;
    s.v1 = rotl64(s.v1, 13);
    s.v1 = s.v1 ^ s.v0;
    s.v0 = rotl64(s.v0, 32);
    s.v2 = s.v2 + s.v3;
    s.v3 = rotl64(s.v3, 16);
    s.v3 = s.v3 ^ s.v2;
    s.v0 = s.v0 + s.v3;
    s.v3 = rotl64(s.v3, 21);
    s.v3 = s.v3 ^ s.v0;
    s.v2 = s.v2 + s.v1;
    s.v1 = rotl64(s.v1, 17);
    s.v1 = s.v1 ^ s.v2;
    s.v2 = rotl64(s.v2, 32);
    return s;
  endfunction

  function automatic siph_state_t sip_absorb(input siph_state_t s, input logic [63:0] m);
    s.v3 = s.v3 ^ m;
    s = sip_round(sip_round(s));
    s.v0 = s.v0 ^ m;
    return s;
  endfunction

  task automatic siphash_step(input logic [63:0] w, input logic [3:0] c, input logic l,
                              output bit emits, output logic [63:0] h);
    logic [63:0] blk;
    int unsigned n;
    emits = 1'b0;
    h = '0;
    if (!msg_open) begin
      mix.v0 = key_lo_q ^ SipC0;
      mix.v1 = key_hi_q ^ SipC1;
      mix.v2 = key_lo_q ^ SipC2;
      mix.v3 = key_hi_q ^ SipC3;
      len_byte = '0;
      msg_open = 1'b1;
    end
    if (!l) begin
      mix = sip_absorb(mix, w);
      len_byte = len_byte + 8'd8;
    end else begin
      n = (c > 4'd8) ? 8 : c;
      if (n == 8) begin
        mix = sip_absorb(mix, w);
        len_byte = len_byte + 8'd8;
        blk = '0;
      end else begin
        blk = w & ((64'd1 << (8 * n)) - 64'd1);
        len_byte = len_byte + 8'(n);
      end
      blk = blk | (64'(len_byte) << LenShift);
      mix = sip_absorb(mix, blk);
      mix.v2 = mix.v2 ^ FinXor;
      repeat (4) mix = sip_round(mix);
      h = mix.v0 ^ mix.v1 ^ mix.v2 ^ mix.v3;
      emits = 1'b1;
      msg_open = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_count++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // entered and left at a falling edge
  task automatic offer_word(input logic [63:0] w, input logic [3:0] c, input logic l,
                            input bit has_hash, input logic [63:0] typed_hash);
    bit          emits;
    logic [63:0] h;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    message_word_i <= w;
    byte_count_i   <= c;
    last_word_i    <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    siphash_step(w, c, l, emits, h);
    if (emits) pending_hashes.push_back(has_hash ? typed_hash : h);
    @(negedge clk_i);
  endtask

  task automatic drain_hashes();
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_KEY_LOW;
    cfg_data_i  <= lo;
    @(negedge clk_i);
    cfg_index_i <= CFG_KEY_HIGH;
    cfg_data_i  <= hi;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    key_lo_q = lo;
    key_hi_q = hi;
  endtask

  task automatic run_random_messages(input int unsigned target);
    int unsigned sent;
    int unsigned words;
    int unsigned pick;
    logic [3:0]  cnt;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 5) words = $urandom_range(40, 30);
      else if (pick < 20) words = 1;
      else words = $urandom_range(6, 2);
      for (int k = 0; k < int'(words) - 1; k++) begin
        cnt = ($urandom_range(99) < 75) ? 4'd8 : 4'($urandom_range(15));
        offer_word({$urandom, $urandom}, cnt, 1'b0, 1'b0, '0);
      end
      cnt = ($urandom_range(99) < 12) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      offer_word({$urandom, $urandom}, cnt, 1'b1, 1'b0, '0);
      sent += words;
    end
  endtask

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_mark != hold_seen) begin
      hold_seen = hold_mark;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hashes.size() == 0) begin
        flag_mismatch("hash with none pending", hash_value_o, '0);
      end else begin
        hash_want = pending_hashes.pop_front();
        if (hash_value_o !== hash_want) flag_mismatch("hash_value", hash_value_o, hash_want);
      end
    end
  end

  initial begin
    #4_800_000;
    $display("** siphash_2_4_stream_core: FAILED **");
    $finish;
  end

  initial begin
    int unsigned send_pcts [NumPhase];
    int unsigned recv_pcts [NumPhase];
    send_pcts = '{0, 66, 0, 26, 0, 26};
    recv_pcts = '{0, 0, 66, 26, 0, 26};
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_KEY_LOW;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    message_word_i = '0;
    byte_count_i   = '0;
    last_word_i    = 1'b0;
    mix            = '0;
    len_byte       = '0;
    msg_open       = 1'b0;
    key_lo_q       = '0;
    key_hi_q       = '0;

    dir_rows = '{
      '{1'b0, 64'h0, 64'h0, 64'h0, 4'd0, 1'b1, 1'b0, 64'h0},
      // standard key, empty message and fifteen-byte message vectors
      '{1'b1, KeyStdLo, KeyStdHi, 64'h0, 4'd0, 1'b1, 1'b1, 64'h726F_DB47_DD0E_0E31},
      '{1'b0, 64'h0, 64'h0, 64'h0706_0504_0302_0100, 4'd8, 1'b0, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 64'h000E_0D0C_0B0A_0908, 4'd7, 1'b1, 1'b1,
        64'hA129_CA61_49BE_45E5},
      '{1'b0, 64'h0, 64'h0, 64'h0706_0504_0302_0100, 4'd8, 1'b1, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, AllOnes, 4'd15, 1'b1, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, AllOnes, 4'd3, 1'b0, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 64'h0, 4'd0, 1'b0, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 64'hA5A5_A5A5_A5A5_A5A5, 4'd1, 1'b1, 1'b0, 64'h0},
      '{1'b1, AllOnes, AllOnes, 64'h0, 4'd8, 1'b0, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, AllOnes, 4'd4, 1'b1, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 64'h0123_4567_89AB_CDEF, 4'd2, 1'b1, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 64'hFEDC_BA98_7654_3210, 4'd5, 1'b1, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 64'h5555_5555_5555_5555, 4'd6, 1'b1, 1'b0, 64'h0},
      '{1'b1, AllOnes, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA, 4'd9, 1'b1, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 64'h0, 4'd3, 1'b1, 1'b0, 64'h0},
      '{1'b1, 64'h0, AllOnes, AllOnes, 4'd7, 1'b0, 1'b0, 64'h0},
      '{1'b0, 64'h0, 64'h0, AllOnes, 4'd0, 1'b1, 1'b0, 64'h0},
      '{1'b1, KeyStdLo, KeyStdHi, 64'h8000_0000_0000_0001, 4'd12, 1'b1, 1'b0, 64'h0}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_key) begin
        drain_hashes();
        load_key(dir_rows[i].key_lo, dir_rows[i].key_hi);
      end
      offer_word(dir_rows[i].word, dir_rows[i].count, dir_rows[i].last,
                 dir_rows[i].has_hash, dir_rows[i].hash);
    end

    for (int p = 0; p < NumPhase; p++) begin
      drain_hashes();
      case (p)
        1:       load_key('0, '0);
        2:       load_key(AllOnes, AllOnes);
        3:       load_key(AllOnes, '0);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      // long receiver hold-off so the core backs up into its input
      if (p == 4) hold_mark++;
      run_random_messages(325);
    end

    drain_hashes();
    repeat (10) @(negedge clk_i);
    if (pending_hashes.size() != 0) flag_mismatch("hash never arrived", '0, pending_hashes[0]);
    if (err_count == 0) begin
      $display("** siphash_2_4_stream_core: PASSED **");
    end else begin
      $display("** siphash_2_4_stream_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/siph_pkg.sv
hdl/siph_dround.sv
hdl/siph_core.sv
hdl/siphash_2_4_stream_core.sv
bench/tb_siphash_2_4_stream_core.sv
